// ===== hw/rtl/wed_pkg.sv =====
package wed_pkg;

    localparam int CHAR_W   = 8;
    localparam int COST_W   = 8;
    localparam int DIST_W   = 17;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_INSERT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELETE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSTITUTE = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_SRC = 2'd0,
        OP_TGT = 2'd1,
        OP_RUN = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_out_item;

    // one row of the table moving along the chain
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              init;
        logic [CHAR_W-1:0] sc;
        logic [DIST_W-1:0] left;
        logic [DIST_W-1:0] diag;
    } t_tok;

    typedef struct packed {
        logic              tgt_wr;
        logic              clr;
        logic [CHAR_W-1:0] sym;
        logic [COST_W-1:0] ins;
        logic [COST_W-1:0] del;
        logic [COST_W-1:0] sub;
    } t_cell_ctrl;

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/wed_chan_if.sv =====
interface wed_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/wed_cell.sv =====
module wed_cell #(
    parameter int LEN_W = 9,
    parameter int IDX   = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wed_pkg::t_cell_ctrl i_ctrl,
    input  logic [LEN_W-1:0]    i_tgt_len,
    input  wed_pkg::t_tok       i_tok,
    output wed_pkg::t_tok       o_tok
);

    logic                          r_active;
    logic [wed_pkg::CHAR_W-1:0]    r_ch;
    logic [wed_pkg::DIST_W-1:0]    r_val;
    wed_pkg::t_tok                 r_tok;

    logic [wed_pkg::DIST_W-1:0]    n_val;
    logic [wed_pkg::DIST_W-1:0]    up_cost;
    logic [wed_pkg::DIST_W-1:0]    left_cost;
    logic [wed_pkg::DIST_W-1:0]    diag_cost;
    logic [wed_pkg::DIST_W-1:0]    m01;
    logic [wed_pkg::COST_W-1:0]    sub;
    logic                          wr_here;

    assign wr_here = i_ctrl.tgt_wr && (i_tgt_len == LEN_W'(IDX));
    assign sub     = (i_tok.sc == r_ch) ? '0 : i_ctrl.sub;

    always_comb begin
        up_cost   = wed_pkg::sat_add(r_val, wed_pkg::DIST_W'(i_ctrl.del));
        left_cost = wed_pkg::sat_add(i_tok.left, wed_pkg::DIST_W'(i_ctrl.ins));
        diag_cost = wed_pkg::sat_add(i_tok.diag, wed_pkg::DIST_W'(sub));
        m01       = (up_cost < left_cost) ? up_cost : left_cost;
        if (i_tok.init) begin
            n_val = left_cost;
        end else begin
            n_val = (m01 < diag_cost) ? m01 : diag_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_ctrl.clr) begin
            r_active <= 1'b0;
        end else if (wr_here) begin
            r_active <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_ch <= i_ctrl.sym;
        end
        if (i_tok.valid && r_active) begin
            r_val <= n_val;
        end
    end

    // cells past the target length pass the row value through untouched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.last <= i_tok.last;
        r_tok.init <= i_tok.init;
        r_tok.sc   <= i_tok.sc;
        r_tok.left <= r_active ? n_val : i_tok.left;
        r_tok.diag <= r_val;
    end

    assign o_tok = r_tok;

endmodule

// ===== hw/rtl/wed_feed.sv =====
module wed_feed #(
    parameter int MAX_LEN = 256,
    parameter int LEN_W   = 9,
    parameter int ADDR_W  = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [LEN_W-1:0]           i_src_len,
    input  logic                       i_src_wr,
    input  logic [wed_pkg::CHAR_W-1:0] i_sym,
    input  logic [wed_pkg::COST_W-1:0] i_del,
    output wed_pkg::t_tok              o_tok,
    output logic                       o_busy
);

    logic [wed_pkg::CHAR_W-1:0] mem [MAX_LEN];
    logic [wed_pkg::CHAR_W-1:0] r_rdata;
    logic                       r_run;
    logic [LEN_W-1:0]           r_k;
    logic [LEN_W-1:0]           r_n;
    logic [wed_pkg::DIST_W-1:0] r_col;
    logic [wed_pkg::DIST_W-1:0] n_col;
    logic                       is_last;

    always_ff @(posedge i_clk) begin
        if (i_src_wr) begin
            mem[i_src_len[ADDR_W-1:0]] <= i_sym;
        end
        r_rdata <= mem[r_k[ADDR_W-1:0]];
    end

    assign is_last = (r_k == r_n);
    assign n_col   = (r_k == '0) ? '0
                   : wed_pkg::sat_add(r_col, wed_pkg::DIST_W'(i_del));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
        end else if (r_run && is_last) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k   <= '0;
            r_n   <= i_src_len;
            r_col <= '0;
        end else if (r_run) begin
            r_k   <= r_k + LEN_W'(1);
            r_col <= n_col;
        end
    end

    // row zero seeds the insert costs, then one source byte per row
    always_comb begin
        o_tok.valid = r_run;
        o_tok.last  = is_last;
        o_tok.init  = (r_k == '0);
        o_tok.sc    = r_rdata;
        o_tok.left  = n_col;
        o_tok.diag  = r_col;
    end

    assign o_busy = r_run;

endmodule

// ===== hw/rtl/weighted_edit_distance_core.sv =====
// Channel | Dir | Modport | Payload
// i_in    | in  | sink    | operation[1:0], symbol[7:0]
// o_out   | out | source  | distance[16:0], overflow
// i_cfg_* | in  | write   | index[1:0], data[7:0] (0 insert, 1 delete, 2 substitute)
//
// A compute item streams its rows one per cycle through a chain of MAX_LEN
// cells, one cell per target byte. Input is held off until the result is
// latched; a stalled result waits in the output register. Reset is
// synchronous, active low; no clearing pass is needed.
module weighted_edit_distance_core #(
    parameter int MAX_LEN = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wed_chan_if.sink                      i_in,
    wed_chan_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [wed_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wed_pkg::COST_W-1:0]    i_cfg_data
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    wed_pkg::t_state             r_state;
    wed_pkg::t_state             n_state;
    logic [wed_pkg::COST_W-1:0]  r_ins;
    logic [wed_pkg::COST_W-1:0]  r_del;
    logic [wed_pkg::COST_W-1:0]  r_sub;
    logic [LEN_W-1:0]            r_src_len;
    logic [LEN_W-1:0]            r_tgt_len;
    logic                        r_dropped;
    logic [wed_pkg::DIST_W-1:0]  r_res_dist;
    logic                        r_res_ovf;
    logic                        r_out_valid;
    wed_pkg::t_out_item          r_out_data;

    logic                        in_ready;
    logic                        accept;
    logic                        start;
    logic                        capture;
    logic                        load;
    logic                        src_full;
    logic                        tgt_full;
    logic                        src_wr;
    logic                        tgt_wr;
    logic                        feed_busy;
    wed_pkg::t_op                op;
    wed_pkg::t_cell_ctrl         ctrl;
    wed_pkg::t_tok               tok [MAX_LEN+1];

    assign op       = wed_pkg::t_op'(i_in.data.operation);
    assign accept   = i_in.valid && in_ready;
    assign src_full = (r_src_len == LEN_W'(MAX_LEN));
    assign tgt_full = (r_tgt_len == LEN_W'(MAX_LEN));
    assign src_wr   = accept && (op == wed_pkg::OP_SRC) && !src_full;
    assign tgt_wr   = accept && (op == wed_pkg::OP_TGT) && !tgt_full;

    always_comb begin
        n_state = r_state;
        case (r_state)
            wed_pkg::ST_IDLE: begin
                if (accept && op == wed_pkg::OP_RUN) begin
                    n_state = wed_pkg::ST_RUN;
                end
            end
            wed_pkg::ST_RUN: begin
                if (tok[MAX_LEN].valid && tok[MAX_LEN].last) begin
                    n_state = wed_pkg::ST_DONE;
                end
            end
            wed_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = wed_pkg::ST_IDLE;
                end
            end
            default: n_state = wed_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = (r_state == wed_pkg::ST_IDLE);
        start    = (r_state == wed_pkg::ST_IDLE) && accept && (op == wed_pkg::OP_RUN);
        capture  = (r_state == wed_pkg::ST_RUN) && tok[MAX_LEN].valid && tok[MAX_LEN].last;
        load     = (r_state == wed_pkg::ST_DONE) && (!r_out_valid || o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wed_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins <= wed_pkg::COST_W'(1);
            r_del <= wed_pkg::COST_W'(1);
            r_sub <= wed_pkg::COST_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wed_pkg::CFG_INSERT:     r_ins <= i_cfg_data;
                wed_pkg::CFG_DELETE:     r_del <= i_cfg_data;
                wed_pkg::CFG_SUBSTITUTE: r_sub <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_len <= '0;
            r_tgt_len <= '0;
            r_dropped <= 1'b0;
        end else if (capture) begin
            r_src_len <= '0;
            r_tgt_len <= '0;
            r_dropped <= 1'b0;
        end else if (accept) begin
            case (op)
                wed_pkg::OP_SRC: begin
                    if (src_full) begin
                        r_dropped <= 1'b1;
                    end else begin
                        r_src_len <= r_src_len + LEN_W'(1);
                    end
                end
                wed_pkg::OP_TGT: begin
                    if (tgt_full) begin
                        r_dropped <= 1'b1;
                    end else begin
                        r_tgt_len <= r_tgt_len + LEN_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_res_dist <= tok[MAX_LEN].left;
            r_res_ovf  <= r_dropped;
        end
        if (load) begin
            r_out_data.distance <= r_res_dist;
            r_out_data.overflow <= r_res_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    always_comb begin
        ctrl.tgt_wr = tgt_wr;
        ctrl.clr    = capture;
        ctrl.sym    = i_in.data.symbol;
        ctrl.ins    = r_ins;
        ctrl.del    = r_del;
        ctrl.sub    = r_sub;
    end

    wed_feed #(
        .MAX_LEN (MAX_LEN),
        .LEN_W   (LEN_W),
        .ADDR_W  (ADDR_W)
    ) u_feed (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_src_len (r_src_len),
        .i_src_wr  (src_wr),
        .i_sym     (i_in.data.symbol),
        .i_del     (r_del),
        .o_tok     (tok[0]),
        .o_busy    (feed_busy)
    );

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        wed_cell #(
            .LEN_W (LEN_W),
            .IDX   (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (ctrl),
            .i_tgt_len (r_tgt_len),
            .i_tok     (tok[g]),
            .o_tok     (tok[g+1])
        );
    end

`ifndef SYNTHESIS
    a_feed_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        feed_busy |-> (r_state == wed_pkg::ST_RUN))
        else $error("row feed active outside compute");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_src_len <= LEN_W'(MAX_LEN)) && (r_tgt_len <= LEN_W'(MAX_LEN)))
        else $error("string length beyond capacity");

    a_done_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wed_pkg::ST_DONE) |-> (r_src_len == '0) && (r_tgt_len == '0)
            && !r_dropped)
        else $error("lengths not cleared after compute");

    a_last_row_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        capture |=> (r_state == wed_pkg::ST_DONE) && !feed_busy)
        else $error("last row left chain while feed still busy");
`endif

endmodule

// ===== tb/weighted_edit_distance_core_tb.sv =====
module weighted_edit_distance_core_tb;

    localparam int MAX_LEN = 256;
    localparam logic [wed_pkg::OP_W-1:0] OP_NONE = 2'd3;   // unused code, block ignores it
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES = 2 * MAX_LEN + 64;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [wed_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [wed_pkg::COST_W-1:0] i_cfg_data;

    wed_chan_if #(.T(wed_pkg::t_in_item)) in_ch ();
    wed_chan_if #(.T(wed_pkg::t_out_item)) out_ch ();

    weighted_edit_distance_core #(
        .MAX_LEN(MAX_LEN)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch.sink),
        .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [wed_pkg::CHAR_W-1:0] src_bytes [MAX_LEN];
    logic [wed_pkg::CHAR_W-1:0] tgt_bytes [MAX_LEN];
    int src_len;
    int tgt_len;
    logic bytes_dropped;
    logic [wed_pkg::COST_W-1:0] ins_cost;
    logic [wed_pkg::COST_W-1:0] del_cost;
    logic [wed_pkg::COST_W-1:0] sub_cost;

    wed_pkg::t_out_item pending_results[$];
    int errors;
    int items_sent;
    int send_idle;
    int recv_idle;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [wed_pkg::DIST_W-1:0] clamp_add(
            input logic [wed_pkg::DIST_W-1:0] a,
            input logic [wed_pkg::COST_W-1:0] c);
        logic [wed_pkg::DIST_W:0] s;
        s = {1'b0, a} + (wed_pkg::DIST_W + 1)'(c);
        return s[wed_pkg::DIST_W] ? {wed_pkg::DIST_W{1'b1}} : s[wed_pkg::DIST_W-1:0];
    endfunction

    // one row of the table at a time, row 0 grows by insert, column 0 by delete
    function automatic logic [wed_pkg::DIST_W-1:0] table_distance();
        logic [wed_pkg::DIST_W-1:0] row [0:MAX_LEN];
        logic [wed_pkg::DIST_W-1:0] diag;
        logic [wed_pkg::DIST_W-1:0] up;
        logic [wed_pkg::DIST_W-1:0] best;
        logic [wed_pkg::DIST_W-1:0] via_sub;
        int i;
        int j;
        row[0] = '0;
        for (j = 1; j <= tgt_len; j++)
            row[j] = clamp_add(row[j-1], ins_cost);
        for (i = 1; i <= src_len; i++) begin
            diag = row[0];
            row[0] = clamp_add(row[0], del_cost);
            for (j = 1; j <= tgt_len; j++) begin
                up = row[j];
                best = clamp_add(up, del_cost);
                if (clamp_add(row[j-1], ins_cost) < best)
                    best = clamp_add(row[j-1], ins_cost);
                via_sub = clamp_add(diag, (src_bytes[i-1] == tgt_bytes[j-1]) ? '0 : sub_cost);
                if (via_sub < best)
                    best = via_sub;
                diag = up;
                row[j] = best;
            end
        end
        return row[tgt_len];
    endfunction

    function automatic void predict_item(input logic [wed_pkg::OP_W-1:0] op,
                                         input logic [wed_pkg::CHAR_W-1:0] sym);
        wed_pkg::t_out_item res;
        if (op != OP_NONE)
            items_sent++;
        case (op)
            wed_pkg::OP_SRC: begin
                if (src_len < MAX_LEN) begin
                    src_bytes[src_len] = sym;
                    src_len++;
                end else begin
                    bytes_dropped = 1'b1;
                end
            end
            wed_pkg::OP_TGT: begin
                if (tgt_len < MAX_LEN) begin
                    tgt_bytes[tgt_len] = sym;
                    tgt_len++;
                end else begin
                    bytes_dropped = 1'b1;
                end
            end
            wed_pkg::OP_RUN: begin
                res.distance = table_distance();
                res.overflow = bytes_dropped;
                pending_results.push_back(res);
                src_len = 0;
                tgt_len = 0;
                bytes_dropped = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // valid stays high after acceptance; the next call or settle() decides
    task automatic send_item(input logic [wed_pkg::OP_W-1:0] op,
                             input logic [wed_pkg::CHAR_W-1:0] sym);
        if ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {op, sym};
        do @(posedge i_clk); while (!in_ch.ready);
        predict_item(op, sym);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // call only while the block is idle
    task automatic set_costs(input logic [wed_pkg::COST_W-1:0] ins,
                             input logic [wed_pkg::COST_W-1:0] del,
                             input logic [wed_pkg::COST_W-1:0] sub);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= wed_pkg::CFG_INSERT;
        i_cfg_data <= ins;
        @(posedge i_clk);
        i_cfg_idx <= wed_pkg::CFG_DELETE;
        i_cfg_data <= del;
        @(posedge i_clk);
        i_cfg_idx <= wed_pkg::CFG_SUBSTITUTE;
        i_cfg_data <= sub;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ins_cost = ins;
        del_cost = del;
        sub_cost = sub;
    endtask

    function automatic logic [wed_pkg::COST_W-1:0] pick_cost();
        int roll;
        roll = $urandom_range(9);
        if (roll < 2)
            return '0;
        if (roll < 4)
            return '1;
        return wed_pkg::COST_W'($urandom_range(255));
    endfunction

    function automatic logic [wed_pkg::CHAR_W-1:0] pick_symbol(
            input bit narrow,
            input logic [wed_pkg::CHAR_W-1:0] base);
        return narrow ? base + wed_pkg::CHAR_W'($urandom_range(3))
                      : wed_pkg::CHAR_W'($urandom_range(255));
    endfunction

    // random source and target words, interleaved, then a compute
    task automatic send_word_pair(input int max_len);
        int n_src;
        int n_tgt;
        int roll;
        bit narrow;
        logic [wed_pkg::CHAR_W-1:0] base;
        n_src = $urandom_range(max_len);
        n_tgt = $urandom_range(max_len);
        narrow = $urandom_range(3) != 0;
        base = wed_pkg::CHAR_W'($urandom_range(255));
        while (n_src + n_tgt > 0) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
                send_item(OP_NONE, wed_pkg::CHAR_W'($urandom_range(255)));
            end else if (roll < 5) begin
                // noise: any operation, a stray compute breaks the pair early
                send_item(wed_pkg::OP_W'($urandom_range(3)),
                          wed_pkg::CHAR_W'($urandom_range(255)));
            end else if ($urandom_range(n_src + n_tgt - 1) < n_src) begin
                send_item(wed_pkg::OP_SRC, pick_symbol(narrow, base));
                n_src--;
            end else begin
                send_item(wed_pkg::OP_TGT, pick_symbol(narrow, base));
                n_tgt--;
            end
        end
        send_item(wed_pkg::OP_RUN, wed_pkg::CHAR_W'($urandom_range(255)));
    endtask

    task automatic test_defaults();
        send_item(wed_pkg::OP_RUN, 8'h00);
        send_item(OP_NONE, 8'hFF);
        send_item(wed_pkg::OP_RUN, 8'hFF);
        send_item(wed_pkg::OP_SRC, 8'h00);
        send_item(wed_pkg::OP_RUN, 8'h00);
        send_item(wed_pkg::OP_TGT, 8'hFF);
        send_item(wed_pkg::OP_RUN, 8'h00);
        send_item(wed_pkg::OP_SRC, 8'h61);
        send_item(wed_pkg::OP_SRC, 8'h62);
        send_item(wed_pkg::OP_TGT, 8'h61);
        send_item(wed_pkg::OP_TGT, 8'h62);
        send_item(wed_pkg::OP_RUN, 8'h00);
        send_item(wed_pkg::OP_SRC, 8'h00);
        send_item(wed_pkg::OP_TGT, 8'hFF);
        send_item(wed_pkg::OP_RUN, 8'h00);
        send_item(wed_pkg::OP_SRC, 8'hAA);
        send_item(wed_pkg::OP_SRC, 8'h55);
        send_item(wed_pkg::OP_TGT, 8'h55);
        send_item(wed_pkg::OP_RUN, 8'h00);
        settle();
    endtask

    task automatic test_zero_costs();
        set_costs('0, '0, '0);
        repeat (4) send_word_pair(8);
        settle();
        set_costs('1, 8'd1, 8'd1);
        repeat (4) send_word_pair(8);
        settle();
        set_costs(8'd1, 8'd1, '1);
        repeat (4) send_word_pair(8);
        settle();
    endtask

    // both strings one past full, then the flag must clear
    task automatic test_full_strings();
        int k;
        set_costs('1, '1, '1);
        for (k = 0; k <= MAX_LEN; k++)
            send_item(wed_pkg::OP_SRC, wed_pkg::CHAR_W'(k));
        for (k = 0; k <= MAX_LEN; k++)
            send_item(wed_pkg::OP_TGT, ~wed_pkg::CHAR_W'(k));
        send_item(wed_pkg::OP_RUN, 8'h00);
        send_item(wed_pkg::OP_RUN, 8'h00);
        settle();
    endtask

    task automatic test_random(input int s_idle, input int r_idle, input int budget);
        int start;
        int last_cfg;
        send_idle = s_idle;
        recv_idle = r_idle;
        start = items_sent;
        last_cfg = items_sent;
        set_costs(pick_cost(), pick_cost(), pick_cost());
        while (items_sent - start < budget) begin
            if (items_sent - last_cfg >= 100) begin
                settle();
                set_costs(pick_cost(), pick_cost(), pick_cost());
                last_cfg = items_sent;
            end
            if ($urandom_range(29) == 0)
                send_word_pair(MAX_LEN);
            else
                send_word_pair(12);
        end
        settle();
    endtask

    always @(posedge i_clk) begin
        wed_pkg::t_out_item want;
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: distance %0d overflow %0d",
                       out_ch.data.distance, out_ch.data.overflow);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.data.distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance,
                           out_ch.data.distance);
                    errors++;
                end
                if (out_ch.data.overflow !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow,
                           out_ch.data.overflow);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        items_sent = 0;
        src_len = 0;
        tgt_len = 0;
        bytes_dropped = 1'b0;
        ins_cost = 8'd1;
        del_cost = 8'd1;
        sub_cost = 8'd2;
        send_idle = 9;
        recv_idle = 88;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_zero_costs();
        test_full_strings();
        test_random(9, 88, 200);
        test_random(88, 9, 200);
        test_random(0, 0, 200);

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("weighted_edit_distance_core test passed");
        else
            $display("weighted_edit_distance_core test failed");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("weighted_edit_distance_core test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/wed_pkg.sv
hw/rtl/wed_chan_if.sv
hw/rtl/wed_cell.sv
hw/rtl/wed_feed.sv
hw/rtl/weighted_edit_distance_core.sv
tb/weighted_edit_distance_core_tb.sv
